[design/tsac_pkg.sv]
// Shared constants and types for the timed slot admission controller.
package tsac_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int TIME_W       = 32;
    localparam int REL_W        = TIME_W + 1;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 7;
    localparam int GRP          = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SLOTS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_SLOTS = 8'd1;

    typedef struct packed {
        logic              release_en;
        logic [TIME_W-1:0] arrival;
        logic [REL_W-1:0]  release_time;
        logic              special;
    } cell_ctrl_t;

endpackage

[design/timed_slot_admission_control.sv]
// Top level of the timed slot admission controller: sequencer, config and cell chain.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_stall    | arrival_time, hold_duration, needs_special
//  out     | out_valid / out_stall  | granted
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each request passes, from acceptance to the next acceptance, through the accept step,
// the parallel release compare in every cell, the registered population count of held
// and special slots in states S_CNT1 and S_CNT2, and the decision that writes the new
// holder into the first free cell along the chain.
// rst_n clears all holder valid flags and both configuration registers at once.
// A waiting result stalls only the decision step; the next request is taken
// while the previous result sits in the output register.
module timed_slot_admission_control #(
    parameter int CAPACITY = tsac_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tsac_pkg::TIME_W-1:0]      arrival_time,
    input  logic [tsac_pkg::TIME_W-1:0]      hold_duration,
    input  logic                             needs_special,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             granted,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tsac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsac_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int REG_W = (CNT_W > tsac_pkg::CFG_DATA_W) ? CNT_W : tsac_pkg::CFG_DATA_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_REL  = 5'b00010,
        S_CNT1 = 5'b00100,
        S_CNT2 = 5'b01000,
        S_DEC  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [REG_W-1:0]            total_reg, total_next;
    logic [REG_W-1:0]            spec_reg, spec_next;
    logic [REG_W-1:0]            data_ext;
    logic [REG_W-1:0]            cap_lim;

    logic [tsac_pkg::TIME_W-1:0] arr_reg;
    logic [tsac_pkg::TIME_W-1:0] dur_reg;
    logic                        want_spec_reg;

    logic                        out_valid_reg;
    logic                        granted_reg;

    logic [CNT_W-1:0]            used_gen;
    logic [CNT_W-1:0]            used_spec;
    logic                        ok;
    logic                        dec_go;

    tsac_pkg::cell_ctrl_t        ctrl;
    logic [CAPACITY:0]           ins;
    logic [CAPACITY-1:0]         cell_valid;
    logic [CAPACITY-1:0]         cell_special;
    logic [CAPACITY-1:0]         cell_vspec;

    // Configuration: always ready, saturate writes at the pool capacity.
    assign cfg_ready = 1'b1;
    assign data_ext  = REG_W'(cfg_data);
    assign cap_lim   = REG_W'(CAPACITY);

    always_comb
    begin
        total_next = total_reg;
        spec_next  = spec_reg;
        if (cfg_valid)
        begin
            if (cfg_index == tsac_pkg::REG_TOTAL_SLOTS)
            begin
                total_next = (data_ext > cap_lim) ? cap_lim : data_ext;
            end
            else if (cfg_index == tsac_pkg::REG_SPECIAL_SLOTS)
            begin
                spec_next = (data_ext > cap_lim) ? cap_lim : data_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            spec_reg  <= '0;
        end
        else
        begin
            total_reg <= total_next;
            spec_reg  <= spec_next;
        end
    end

    // Grant check: room in the pool and, for special requests, a special slot.
    assign ok = (REG_W'(used_gen) < total_reg) &&
                (!want_spec_reg || (REG_W'(used_spec) < spec_reg));

    // Decide only when the output register can take the result.
    assign dec_go = (state_reg == S_DEC) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_REL;
            S_REL:  state_next = S_CNT1;
            S_CNT1: state_next = S_CNT2;
            S_CNT2: state_next = S_DEC;
            S_DEC:  if (dec_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (dec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request and the result payload. Reject when the insert token
    // falls off the end of the chain without finding a free cell.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            arr_reg       <= arrival_time;
            dur_reg       <= hold_duration;
            want_spec_reg <= needs_special;
        end
        if (dec_go)
        begin
            granted_reg <= ok && !ins[CAPACITY];
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;

    // Broadcast to the cells; the insert token ripples to the first free cell.
    assign ctrl.release_en   = (state_reg == S_REL);
    assign ctrl.arrival      = arr_reg;
    assign ctrl.release_time = {1'b0, arr_reg} + {1'b0, dur_reg};
    assign ctrl.special      = want_spec_reg;
    assign ins[0]            = dec_go && ok;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        tsac_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .ins_in  (ins[i]),
            .ins_out (ins[i+1]),
            .valid   (cell_valid[i]),
            .special (cell_special[i])
        );
    end

    assign cell_vspec = cell_valid & cell_special;

    tsac_count #(.N(CAPACITY)) u_cnt_gen (
        .clk   (clk),
        .bits  (cell_valid),
        .total (used_gen)
    );

    tsac_count #(.N(CAPACITY)) u_cnt_spec (
        .clk   (clk),
        .bits  (cell_vspec),
        .total (used_spec)
    );

endmodule

[design/tsac_cell.sv]
// One holder cell: valid flag, release time and special flag of one slot.
module tsac_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tsac_pkg::cell_ctrl_t ctrl,
    input  logic                ins_in,
    output logic                ins_out,
    output logic                valid,
    output logic                special
);

    logic                       valid_reg;
    logic [tsac_pkg::REL_W-1:0] release_reg;
    logic                       special_reg;
    logic                       take;
    logic                       expire;

    assign take    = ins_in && !valid_reg;
    assign expire  = ctrl.release_en && valid_reg &&
                     (release_reg <= {1'b0, ctrl.arrival});
    assign ins_out = ins_in && valid_reg;
    assign valid   = valid_reg;
    assign special = special_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (expire)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            release_reg <= ctrl.release_time;
            special_reg <= ctrl.special;
        end
    end

endmodule

[design/tsac_count.sv]
// Two-stage registered population count over the holder flags.
module tsac_count #(
    parameter int N = tsac_pkg::CAPACITY_DEF
) (
    input  logic                   clk,
    input  logic [N-1:0]           bits,
    output logic [$clog2(N+1)-1:0] total
);

    localparam int NGRP = (N + tsac_pkg::GRP - 1) / tsac_pkg::GRP;
    localparam int GW   = $clog2(tsac_pkg::GRP + 1);
    localparam int CW   = $clog2(N + 1);

    logic [NGRP*tsac_pkg::GRP-1:0] padded;
    logic [GW-1:0]                 grp_next [NGRP];
    logic [GW-1:0]                 grp_reg  [NGRP];
    logic [CW-1:0]                 total_next;
    logic [CW-1:0]                 total_reg;

    always_comb
    begin
        padded        = '0;
        padded[N-1:0] = bits;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < tsac_pkg::GRP; b++)
            begin
                grp_next[g] = grp_next[g] + GW'(padded[g*tsac_pkg::GRP+b]);
            end
        end
    end

    always_comb
    begin
        total_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total_next = total_next + CW'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        total_reg <= total_next;
    end

    assign total = total_reg;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the timed slot admission controller: directed and random requests.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = tsac_pkg::CAPACITY_DEF;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 4;
    // Leave a margin after the last result.
    localparam int DRAIN_CYCLES = 12;
    // Abort when no channel has moved anything for this many cycles.
    localparam int IDLE_LIMIT   = 4000;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [tsac_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO =
        tsac_pkg::REG_SPECIAL_SLOTS + 1'b1;
    localparam logic [tsac_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    localparam logic [tsac_pkg::TIME_W-1:0] TIME_MAX   = '1;
    // Longer than any hold the random traffic can ask for, so a jump frees every slot.
    localparam logic [tsac_pkg::TIME_W-1:0] PHASE_JUMP = 32'h0010_0000;

    typedef struct packed {
        logic [tsac_pkg::TIME_W-1:0] arrival;
        logic [tsac_pkg::TIME_W-1:0] hold;
        logic                        special;
    } slot_req_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            in_valid      = 1'b0;
    logic                            in_stall;
    logic [tsac_pkg::TIME_W-1:0]     arrival_time  = '0;
    logic [tsac_pkg::TIME_W-1:0]     hold_duration = '0;
    logic                            needs_special = 1'b0;
    logic                            out_valid;
    logic                            out_stall     = 1'b0;
    logic                            granted;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [tsac_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [tsac_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    timed_slot_admission_control dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .arrival_time  (arrival_time),
        .hold_duration (hold_duration),
        .needs_special (needs_special),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Admission predictor: its own copy of the slot table and the limits.
    // ------------------------------------------------------------------
    logic                       slot_held    [CAP] = '{default: 1'b0};
    logic [tsac_pkg::REL_W-1:0] slot_release [CAP];
    logic                       slot_special [CAP];
    int unsigned                held_general  = 0;
    int unsigned                held_special  = 0;
    int unsigned                general_limit = 0;
    int unsigned                special_limit = 0;

    // Clip a register value to the pool size.
    function automatic int unsigned saturate_slots(
        input logic [tsac_pkg::CFG_DATA_W-1:0] value);
        return (value > CAP) ? CAP : int'(value);
    endfunction

    // Free expired holders, decide the request, and claim a slot when it is granted.
    function automatic logic admit_request(input slot_req_t req);
        logic [tsac_pkg::REL_W-1:0] arrival_ext;
        logic                       ok;
        int                         free_slot;
        arrival_ext = {1'b0, req.arrival};
        for (int i = 0; i < CAP; i++)
        begin
            if (slot_held[i] && slot_release[i] <= arrival_ext)
            begin
                slot_held[i] = 1'b0;
                if (held_general > 0)
                    held_general--;
                if (slot_special[i] && held_special > 0)
                    held_special--;
            end
        end
        ok = held_general < general_limit;
        if (ok && req.special)
            ok = held_special < special_limit;
        free_slot = -1;
        if (ok)
        begin
            for (int i = 0; i < CAP && free_slot < 0; i++)
            begin
                if (!slot_held[i])
                    free_slot = i;
            end
            if (free_slot < 0)
                ok = 1'b0;
        end
        if (ok)
        begin
            slot_held[free_slot]    = 1'b1;
            // Release time is a 33-bit sum: a long hold near the top of time never wraps.
            slot_release[free_slot] = arrival_ext + req.hold;
            slot_special[free_slot] = req.special;
            held_general++;
            if (req.special)
                held_special++;
        end
        return ok;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping between stimulus, driver and monitor.
    // ------------------------------------------------------------------
    slot_req_t   pending_reqs   [$];
    logic        grant_expected [$];
    int unsigned reqs_queued = 0;
    int unsigned reqs_taken  = 0;
    int unsigned mismatches  = 0;
    bit          quiet_tail  = 1'b0;
    int unsigned send_gap    = 0;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;
    logic [tsac_pkg::TIME_W-1:0] req_time = '0;

    // ------------------------------------------------------------------
    // Request driver: predict on every accepted request, then load the next
    // one from the pending queue or insert an idle burst. Hold the payload
    // steady while the block stalls.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        slot_req_t taken_req;
        slot_req_t next_req;
        logic      predicted;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken_req.arrival = arrival_time;
                taken_req.hold    = hold_duration;
                taken_req.special = needs_special;
                predicted         = admit_request(taken_req);
                grant_expected    = {grant_expected, predicted};
                reqs_taken++;
            end
            // Advance only when the slot on the wire is empty or just accepted.
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!quiet_tail && pending_reqs.size() > 0
                         && $urandom_range(0, 9) == 0)
                begin
                    // Start an idle burst.
                    send_gap = $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    next_req = pending_reqs.pop_front();
                    in_valid      <= 1'b1;
                    arrival_time  <= next_req.arrival;
                    hold_duration <= next_req.hold;
                    needs_special <= next_req.special;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest
    // prediction, and stall the output in random bursts.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        logic expected_grant;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (grant_expected.size() == 0)
                begin
                    $error("granted: expected no result, actual %0b", granted);
                    mismatches++;
                end
                else
                begin
                    expected_grant = grant_expected.pop_front();
                    if (granted !== expected_grant)
                    begin
                        $error("granted: expected %0b, actual %0b", expected_grant, granted);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Abort when no request, result or register write has moved for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [tsac_pkg::TIME_W-1:0] arrival,
                                 input logic [tsac_pkg::TIME_W-1:0] hold,
                                 input logic special);
        slot_req_t req;
        req.arrival  = arrival;
        req.hold     = hold;
        req.special  = special;
        pending_reqs = {pending_reqs, req};
        reqs_queued++;
    endtask

    // Wait until every queued request is taken and answered, then let the pipe settle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (reqs_taken != reqs_queued || grant_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register and mirror it in the predictor at the handshake edge.
    task automatic write_reg(input logic [tsac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsac_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == tsac_pkg::REG_TOTAL_SLOTS)
            general_limit = saturate_slots(value);
        else if (idx == tsac_pkg::REG_SPECIAL_SLOTS)
            special_limit = saturate_slots(value);
    endtask

    // Drain, load new limits and optionally skip far enough ahead to free every slot.
    task automatic reconfigure(input logic [tsac_pkg::CFG_DATA_W-1:0] total,
                               input logic [tsac_pkg::CFG_DATA_W-1:0] special,
                               input bit jump);
        wait_idle();
        write_reg(tsac_pkg::REG_TOTAL_SLOTS, total);
        write_reg(tsac_pkg::REG_SPECIAL_SLOTS, special);
        if (jump)
            req_time = req_time + PHASE_JUMP;
    endtask

    // Mostly forward-moving arrivals with holds scaled to the pool, so the pool
    // fills and drains; mix in late arrivals, zero holds, long holds and
    // same-time bursts.
    task automatic run_traffic(input int count, input int unsigned step_max);
        int unsigned span;
        int unsigned back;
        int          k;
        logic [tsac_pkg::TIME_W-1:0] arrival;
        logic [tsac_pkg::TIME_W-1:0] hold;
        span = 2 * step_max * ((general_limit == 0) ? 1 : general_limit);
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    // Late arrival: at or before the latest time seen.
                    back = $urandom_range(0, 4 * step_max);
                    if (back > req_time)
                        back = req_time;
                    arrival = req_time - back;
                    hold    = $urandom_range(0, span);
                end
                1:
                begin
                    arrival = req_time;
                    hold    = '0;
                end
                2:
                begin
                    arrival = req_time;
                    hold    = $urandom_range(span, 8 * span);
                end
                3:
                begin
                    arrival = req_time;
                    hold    = $urandom_range(0, span);
                end
                default:
                begin
                    req_time = req_time + $urandom_range(1, step_max);
                    arrival  = req_time;
                    hold     = $urandom_range(0, span);
                end
            endcase
            queue_request(arrival, hold, 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Limits are zero out of reset: turn everything away, extremes included.
        queue_request('0, '0, 1'b0);
        queue_request(TIME_MAX, TIME_MAX, 1'b1);

        // Two slots, one of them special: fill, reject, release on the boundary.
        reconfigure(7'd2, 7'd1, 1'b0);
        queue_request(32'd10, 32'd0, 1'b0);     // zero hold still takes a slot
        queue_request(32'd5, 32'd100, 1'b1);
        queue_request(32'd6, 32'd1, 1'b0);      // pool full
        queue_request(32'd10, 32'd5, 1'b0);     // frees the zero-hold slot exactly at its time
        queue_request(32'd11, 32'd5, 1'b1);
        queue_request(32'd105, 32'd0, 1'b1);
        queue_request(32'd105, 32'd0, 1'b1);
        queue_request(32'd106, 32'd50, 1'b1);
        queue_request(32'd107, 32'd50, 1'b1);   // special slot taken
        queue_request(32'd108, 32'd50, 1'b0);

        // No special slots at all.
        reconfigure(7'd1, 7'd0, 1'b0);
        queue_request(32'd400, 32'd10, 1'b1);
        queue_request(32'd400, 32'd10, 1'b0);

        // Drop writes to unlisted indexes; the limits must survive them.
        wait_idle();
        write_reg(REG_UNUSED_LO, '0);
        write_reg(REG_UNUSED_HI, '1);
        queue_request(32'd420, 32'd5, 1'b0);
        queue_request(32'd421, 32'd5, 1'b0);

        req_time = 32'd1000;
        reconfigure(7'd4, 7'd2, 1'b1);
        run_traffic(160, 64);
        // Both registers above the pool size: saturate.
        reconfigure(7'd127, 7'd65, 1'b1);
        run_traffic(220, 32);
        // Lower the limit under current usage: hold rejections until slots expire.
        reconfigure(7'd2, 7'd0, 1'b0);
        run_traffic(130, 128);
        reconfigure(7'd1, 7'd1, 1'b1);
        run_traffic(130, 256);
        reconfigure(7'd16, 7'd127, 1'b1);
        run_traffic(160, 64);
        // Zero slots with holders still live.
        reconfigure(7'd0, 7'd0, 1'b0);
        run_traffic(40, 64);
        reconfigure(7'd64, 7'd8, 1'b1);
        run_traffic(220, 16);

        // Run the tail without idling on either side.
        quiet_tail = 1'b1;
        reconfigure(7'd8, 7'd4, 1'b0);
        run_traffic(170, 64);

        // Top of time: a maximal hold must release past 2^32, not wrap below it.
        reconfigure(7'd1, 7'd1, 1'b0);
        queue_request(TIME_MAX, '0, 1'b0);
        queue_request(TIME_MAX, TIME_MAX, 1'b1);
        queue_request(TIME_MAX, '0, 1'b0);
        queue_request(TIME_MAX, TIME_MAX, 1'b0);

        wait_idle();
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[timed_slot_admission_control.f]
design/tsac_pkg.sv
design/tsac_cell.sv
design/tsac_count.sv
design/timed_slot_admission_control.sv
tb/tb_top.sv
